// ----- rtl/core/mono_color_expand_blit_macros.svh -----
// assertion macros for the mono color expansion blit checker
`ifndef MONO_COLOR_EXPAND_BLIT_MACROS_SVH
`define MONO_COLOR_EXPAND_BLIT_MACROS_SVH

// same-cycle implication under active-low reset
`define MCEB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mceb same-cycle check failed");

// next-cycle implication under active-low reset
`define MCEB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mceb next-cycle check failed");

`endif

// ----- rtl/core/mceb_pkg.sv -----
// package with types, register codes and helpers for the mono color expansion blit
`default_nettype none
package mceb_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = $clog2(MAX_DIMENSION);
  localparam int CFG_DIM_W     = 13;
  localparam int PIX_W         = 32;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TOTAL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_XOR_MODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 3'd5;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] row_width;
    logic [CFG_DIM_W-1:0] row_total;
    logic [PIX_W-1:0]     fg_color;
    logic [PIX_W-1:0]     bg_color;
    logic                 xor_mode;
    logic [2:0]           pixel_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       src_byte;
    logic [PIX_W-1:0] old_pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] new_pixel;
    logic             write_pixel;
    logic             took_source_byte;
    logic             end_of_row;
    logic             end_of_frame;
  } out_t;

  function automatic logic [PIX_W-1:0] pixel_mask(input logic [2:0] nbytes);
    logic [PIX_W-1:0] m;
    begin
      case (nbytes)
        3'd0, 3'd1: m = 32'h0000_00FF;
        3'd2:       m = 32'h0000_FFFF;
        3'd3:       m = 32'h00FF_FFFF;
        default:    m = 32'hFFFF_FFFF;
      endcase
      return m;
    end
  endfunction

  function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [CFG_DIM_W-1:0] r;
    begin
      if (v == '0) begin
        r = CFG_DIM_W'(1);
      end else if (v > CFG_DIM_W'(MAX_DIMENSION)) begin
        r = CFG_DIM_W'(MAX_DIMENSION);
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mono_color_expand_blit.sv -----
// top level of the mono color expansion blit: counters, shifter, config and output skid
// an accepted beat goes into the result register, or into the skid stage while the output is stalled
// throughput: one pixel beat per cycle while in_stall is low, set by the single result register with its skid stage
// in_stall rises only when the skid stage holds a beat behind a stalled output
// rst_n (synchronous) clears counters, shifter, valid flags and loads register defaults
`default_nettype none
module mono_color_expand_blit
  import mceb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data
);

  cfg_t             cfg_r;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             out_valid_r;
  out_t             out_data_r;
  logic             skid_valid_r;
  out_t             skid_data_r;

  logic                 accept;
  logic                 took;
  logic [7:0]           cur_byte;
  logic [CFG_DIM_W-1:0] width_c;
  logic [CFG_DIM_W-1:0] height_c;
  logic [CFG_DIM_W-1:0] col_inc;
  logic [CFG_DIM_W-1:0] row_inc;
  logic                 eor;
  logic                 eof;
  logic [PIX_W-1:0]     pix;
  logic                 pix_wr;
  out_t                 res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_width   <= CFG_DIM_W'(8);
      cfg_r.row_total   <= CFG_DIM_W'(1);
      cfg_r.fg_color    <= '1;
      cfg_r.bg_color    <= '0;
      cfg_r.xor_mode    <= 1'b0;
      cfg_r.pixel_bytes <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_WIDTH:   cfg_r.row_width   <= cfg_data[CFG_DIM_W-1:0];
        REG_ROW_TOTAL:   cfg_r.row_total   <= cfg_data[CFG_DIM_W-1:0];
        REG_FG_COLOR:    cfg_r.fg_color    <= cfg_data;
        REG_BG_COLOR:    cfg_r.bg_color    <= cfg_data;
        REG_XOR_MODE:    cfg_r.xor_mode    <= cfg_data[0];
        REG_PIXEL_BYTES: cfg_r.pixel_bytes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // rectangle walk and bit shifter
  assign took     = (col_r[2:0] == 3'd0);
  assign cur_byte = took ? in_data.src_byte : shift_r;
  assign width_c  = clamp_dim(cfg_r.row_width);
  assign height_c = clamp_dim(cfg_r.row_total);
  assign col_inc  = CFG_DIM_W'(col_r) + CFG_DIM_W'(1);
  assign row_inc  = CFG_DIM_W'(row_r) + CFG_DIM_W'(1);
  assign eor      = (col_inc >= width_c);
  assign eof      = eor && (row_inc >= height_c);

  always_comb begin
    if (eor) begin
      col_nxt   = '0;
      shift_nxt = '0;
      row_nxt   = eof ? '0 : row_inc[DIM_W-1:0];
    end else begin
      col_nxt   = col_inc[DIM_W-1:0];
      shift_nxt = {cur_byte[6:0], 1'b0};
      row_nxt   = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      shift_r <= '0;
    end else if (accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      shift_r <= shift_nxt;
    end
  end

  mceb_pixel u_pixel (
    .cfg         (cfg_r),
    .src_bit     (cur_byte[7]),
    .old_pixel   (in_data.old_pixel),
    .new_pixel   (pix),
    .write_pixel (pix_wr)
  );

  always_comb begin
    res.new_pixel        = pix;
    res.write_pixel      = pix_wr;
    res.took_source_byte = took;
    res.end_of_row       = eor;
    res.end_of_frame     = eof;
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || !out_stall) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= accept;
        end
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= res;
      end
    end else if (accept) begin
      skid_data_r <= res;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mceb_pixel.sv -----
// pixel datapath: copy or xor expansion of one source bit, masked to pixel width
`default_nettype none
module mceb_pixel
  import mceb_pkg::*;
(
  input  cfg_t             cfg,
  input  logic             src_bit,
  input  logic [PIX_W-1:0] old_pixel,
  output logic [PIX_W-1:0] new_pixel,
  output logic             write_pixel
);

  logic [PIX_W-1:0] mask;
  logic [PIX_W-1:0] fg;
  logic [PIX_W-1:0] bg;
  logic [PIX_W-1:0] oldm;

  assign mask = pixel_mask(cfg.pixel_bytes);
  assign fg   = cfg.fg_color & mask;
  assign bg   = cfg.bg_color & mask;
  assign oldm = old_pixel & mask;

  always_comb begin
    if (!cfg.xor_mode) begin
      new_pixel   = src_bit ? fg : bg;
      write_pixel = 1'b1;
    end else if (src_bit) begin
      new_pixel   = (oldm == bg) ? fg : bg;
      write_pixel = 1'b1;
    end else begin
      new_pixel   = oldm;
      write_pixel = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mceb_checker.sv -----
// port-level checker for the mono color expansion blit, bound to the top level
`default_nettype none
`include "mono_color_expand_blit_macros.svh"
module mceb_checker
  import mceb_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic in_busy;
  assign in_busy = in_valid && in_stall;

  `MCEB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `MCEB_ASSERT_NOW(a_eof_is_eor, clk, rst_n, out_valid && out_data.end_of_frame, out_data.end_of_row)
  `MCEB_ASSERT_NOW(a_stall_needs_out, clk, rst_n, in_stall, out_valid)
  `MCEB_ASSERT_NEXT(a_skid_drains, clk, rst_n, in_stall && !out_stall, !in_stall)
  `MCEB_ASSERT_NEXT(a_busy_keeps_out, clk, rst_n, in_busy && out_stall, in_stall && out_valid)

endmodule

bind mono_color_expand_blit mceb_checker u_mceb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ----- tb/pixel_expand_checker.sv -----
`timescale 1ns / 1ps
// checker for the blit: predicts each expanded pixel and compares it with the result beats
module pixel_expand_checker
  import mceb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   pixels_in_flight
);

  logic [CFG_DIM_W-1:0] width_reg;
  logic [CFG_DIM_W-1:0] height_reg;
  logic [PIX_W-1:0]     fg_reg;
  logic [PIX_W-1:0]     bg_reg;
  logic                 xor_reg;
  logic [2:0]           bytes_reg;
  logic [DIM_W-1:0]     col_pos;
  logic [DIM_W-1:0]     row_pos;
  logic [7:0]           bit_buf;
  out_t                 expected_pixels[$];

  function automatic int dim_limit(input logic [CFG_DIM_W-1:0] v);
    int n;
    n = int'(v);
    if (n == 0) begin
      n = 1;
    end else if (n > MAX_DIMENSION) begin
      n = MAX_DIMENSION;
    end
    return n;
  endfunction

  function automatic out_t expand_next_pixel(input in_t px);
    out_t             res;
    logic [PIX_W-1:0] mask;
    logic [PIX_W-1:0] old_m;
    logic [PIX_W-1:0] fg_m;
    logic [PIX_W-1:0] bg_m;
    int               nbytes;
    logic             src_bit;
    nbytes = (bytes_reg == 3'd0) ? 1 : (bytes_reg > 3'd4) ? 4 : int'(bytes_reg);
    mask = (nbytes == 4) ? '1 : ((PIX_W'(1) << (8 * nbytes)) - PIX_W'(1));
    old_m = px.old_pixel & mask;
    fg_m = fg_reg & mask;
    bg_m = bg_reg & mask;
    res.took_source_byte = (col_pos[2:0] == 3'd0);
    if (res.took_source_byte) begin
      bit_buf = px.src_byte;
    end
    src_bit = bit_buf[7];
    if (!xor_reg) begin
      res.new_pixel = src_bit ? fg_m : bg_m;
      res.write_pixel = 1'b1;
    end else if (src_bit) begin
      res.new_pixel = (old_m == bg_m) ? fg_m : bg_m;
      res.write_pixel = 1'b1;
    end else begin
      res.new_pixel = old_m;
      res.write_pixel = 1'b0;
    end
    bit_buf = {bit_buf[6:0], 1'b0};
    res.end_of_row = (int'(col_pos) + 1 >= dim_limit(width_reg));
    res.end_of_frame = res.end_of_row && (int'(row_pos) + 1 >= dim_limit(height_reg));
    if (res.end_of_row) begin
      col_pos = '0;
      bit_buf = '0;
      row_pos = res.end_of_frame ? '0 : row_pos + DIM_W'(1);
    end else begin
      col_pos = col_pos + DIM_W'(1);
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [PIX_W-1:0] want,
                             input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      width_reg = CFG_DIM_W'(8);
      height_reg = CFG_DIM_W'(1);
      fg_reg = '1;
      bg_reg = '0;
      xor_reg = 1'b0;
      bytes_reg = 3'd4;
      col_pos = '0;
      row_pos = '0;
      bit_buf = '0;
      expected_pixels.delete();
      pixels_in_flight = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result beat with no pixel pending: %h", out_data);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("new_pixel", want.new_pixel, out_data.new_pixel);
          check_field("write_pixel", PIX_W'(want.write_pixel),
                      PIX_W'(out_data.write_pixel));
          check_field("took_source_byte", PIX_W'(want.took_source_byte),
                      PIX_W'(out_data.took_source_byte));
          check_field("end_of_row", PIX_W'(want.end_of_row),
                      PIX_W'(out_data.end_of_row));
          check_field("end_of_frame", PIX_W'(want.end_of_frame),
                      PIX_W'(out_data.end_of_frame));
        end
      end
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(expand_next_pixel(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_WIDTH:   width_reg = cfg_data[CFG_DIM_W-1:0];
          REG_ROW_TOTAL:   height_reg = cfg_data[CFG_DIM_W-1:0];
          REG_FG_COLOR:    fg_reg = cfg_data;
          REG_BG_COLOR:    bg_reg = cfg_data;
          REG_XOR_MODE:    xor_reg = cfg_data[0];
          REG_PIXEL_BYTES: bytes_reg = cfg_data[2:0];
          default: ;
        endcase
      end
      pixels_in_flight = expected_pixels.size();
    end
  end

endmodule

// ----- tb/tb_mono_color_expand_blit.sv -----
`timescale 1ns / 1ps
// testbench top for the mono color expansion blit: stimulus, idling, timeout and verdict
module tb_mono_color_expand_blit;
  import mceb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PIX_W-1:0]     cfg_data;

  int               mismatch_count;
  int               pixels_in_flight;
  int               cycle_count = 0;
  bit               idle_on = 1'b1;
  bit               hold_req = 1'b0;
  logic [PIX_W-1:0] fg_shadow = '1;
  logic [PIX_W-1:0] bg_shadow = '0;

  mono_color_expand_blit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_expand_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .pixels_in_flight (pixels_in_flight)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stall per beat, plus one long hold-off on request
  initial begin
    int stall_len;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall_len = idle_on ? $urandom_range(0, 8) : 0;
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // valid stays high after a beat so back-to-back beats need no toggle
  task automatic send_pixel(input in_t px);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(negedge clk); while (pixels_in_flight != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry junk
  task automatic set_frame(input int w, input int h, input logic [PIX_W-1:0] fg,
                           input logic [PIX_W-1:0] bg, input bit xor_on, input int nb);
    write_reg(REG_ROW_WIDTH, {19'($urandom()), 13'(w)});
    write_reg(REG_ROW_TOTAL, {19'($urandom()), 13'(h)});
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
    write_reg(REG_XOR_MODE, {31'($urandom()), xor_on});
    write_reg(REG_PIXEL_BYTES, {29'($urandom()), 3'(nb)});
    fg_shadow = fg;
    bg_shadow = bg;
  endtask

  task automatic random_frame();
    int               w;
    int               h;
    logic [PIX_W-1:0] fg;
    logic [PIX_W-1:0] bg;
    case ($urandom_range(0, 9))
      0:       w = 0;
      1:       w = $urandom_range(4097, 8191);
      2:       w = $urandom_range(21, 64);
      default: w = $urandom_range(1, 20);
    endcase
    case ($urandom_range(0, 7))
      0:       h = 0;
      1:       h = 4096;
      2:       h = $urandom_range(4097, 8191);
      default: h = $urandom_range(1, 6);
    endcase
    fg = $urandom();
    bg = ($urandom_range(0, 5) == 0) ? fg : $urandom();
    set_frame(w, h, fg, bg, 1'($urandom_range(0, 1)), $urandom_range(0, 7));
  endtask

  // old pixels often match the colors so both toggle outcomes show up
  function automatic in_t random_pixel();
    in_t px;
    px.src_byte = 8'($urandom());
    case ($urandom_range(0, 4))
      0:       px.old_pixel = bg_shadow;
      1:       px.old_pixel = {24'($urandom()), bg_shadow[7:0]};
      2:       px.old_pixel = {16'($urandom()), bg_shadow[15:0]};
      3:       px.old_pixel = fg_shadow;
      default: px.old_pixel = $urandom();
    endcase
    return px;
  endfunction

  initial begin
    int i;
    int phase;
    int beats;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROW_WIDTH;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: 8-pixel rows, one row, then wrap into the next frame
    send_pixel({8'hA5, 32'h0000_0000});
    for (i = 0; i < 8; i++) begin
      send_pixel({8'($urandom()), i[0] ? 32'hFFFF_FFFF : 32'h0000_0000});
    end
    drain_pixels();

    // toggle mode, 2-byte pixels, short rows
    set_frame(3, 2, 32'h5A5A_C3C3, 32'hFFFF_1234, 1'b1, 2);
    send_pixel({8'hB6, 32'hABCD_1234});
    send_pixel({8'h00, 32'h0000_C3C3});
    for (i = 0; i < 3; i++) begin
      send_pixel(random_pixel());
    end
    drain_pixels();

    // zero width and height, zero pixel bytes
    set_frame(0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 0);
    for (i = 0; i < 3; i++) begin
      send_pixel(random_pixel());
    end
    drain_pixels();

    set_frame(8, 8191, 32'h1357_9BDF, 32'h2468_ACE0, 1'b0, 7);
    for (i = 0; i < 5; i++) begin
      send_pixel(random_pixel());
    end
    drain_pixels();

    // shrink the rectangle under the running column
    set_frame(2, 3, 32'hFFFF_FFFF, 32'h8000_0001, 1'b1, 5);
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    for (i = 0; i < 3; i++) begin
      send_pixel(random_pixel());
    end

    for (phase = 0; phase < PHASES; phase++) begin
      drain_pixels();
      if (phase == 4) begin
        // widest clamped row, no idling
        set_frame(8191, 1, $urandom(), $urandom(), 1'($urandom_range(0, 1)), 3);
        idle_on = 1'b0;
        beats = 60;
      end else begin
        random_frame();
        idle_on = (phase % 3 != 2);
        beats = 85;
      end
      if (phase == 6) begin
        hold_req = 1'b1;
      end
      for (i = 0; i < beats; i++) begin
        send_pixel(random_pixel());
      end
    end

    drain_pixels();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mceb_pkg.sv
rtl/core/mceb_pixel.sv
rtl/core/mono_color_expand_blit.sv
rtl/core/mceb_checker.sv
tb/pixel_expand_checker.sv
tb/tb_mono_color_expand_blit.sv
